### design/hclb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hclb_pkg
// Shared types and constants of the Huffman code length builder.
// ----------------------------------------------------------------------------
package hclb_pkg;

    localparam int SYM_BITS    = 7;
    localparam int SYMBOLS     = 128;
    localparam int COUNT_BITS  = 20;
    localparam int WEIGHT_BITS = 27;
    localparam int LEN_BITS    = 7;
    localparam int HIDX_BITS   = 8;

    localparam logic [1:0] ACT_COUNT  = 2'd0;
    localparam logic [1:0] ACT_BUILD  = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [SYM_BITS-1:0]   NEWLINE   = 7'd10;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0]   LEN_MAX   = {LEN_BITS{1'b1}};

    typedef struct packed {
        logic [1:0]          action;
        logic [SYM_BITS-1:0] symbol;
    } t_req;

    typedef struct packed {
        logic                reply_kind;
        logic [7:0]          distinct_symbols;
        logic [LEN_BITS-1:0] code_length;
    } t_rsp;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic [SYM_BITS-1:0]    group;
    } t_heap;

endpackage

### design/huffman_code_length_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_length_builder
// Symbol histogram plus a memory-based min-heap Huffman length builder.
// ----------------------------------------------------------------------------
// A count request reads the count RAM, then writes it back in S_CNT; a
// count of a newline is dropped in S_IDLE. A read request reads the length
// RAM and its reply strobe is registered out of S_RDL. A build walks the
// heap RAM over one read port: the histogram scan checks every symbol and
// pushes each present one with a sift-up (S_SUR, S_SUC per level); each pop
// reads the root and the last entry (S_POP0..S_POP2), then sifts down via
// S_SD, S_SDL, S_SDR per level (S_SD, S_SDL1 with only a left child); each
// merge runs a group scan over all symbols, with S_MRG2 for present ones.
// busy is high until the request is finished; replies last one cycle on
// o_strobe and the receiver cannot stall them. Histogram and length RAMs
// read as zero after reset through per-entry valid flops, so no clearing
// pass is needed.
module huffman_code_length_builder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  hclb_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_strobe,
    output hclb_pkg::t_rsp  o_rsp
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CNT  = 5'd1;
    localparam logic [4:0] S_RDL  = 5'd2;
    localparam logic [4:0] S_INS  = 5'd3;
    localparam logic [4:0] S_INSG = 5'd4;
    localparam logic [4:0] S_SUR  = 5'd5;
    localparam logic [4:0] S_SUC  = 5'd6;
    localparam logic [4:0] S_CHK  = 5'd7;
    localparam logic [4:0] S_POP0 = 5'd8;
    localparam logic [4:0] S_POP1 = 5'd9;
    localparam logic [4:0] S_POP2 = 5'd10;
    localparam logic [4:0] S_SD   = 5'd11;
    localparam logic [4:0] S_SDL  = 5'd12;
    localparam logic [4:0] S_SDR  = 5'd13;
    localparam logic [4:0] S_SDL1 = 5'd14;
    localparam logic [4:0] S_MRG  = 5'd15;
    localparam logic [4:0] S_MRG2 = 5'd16;
    localparam logic [4:0] S_DONE = 5'd17;

    // Memories
    logic [hclb_pkg::COUNT_BITS-1:0] m_cnt [hclb_pkg::SYMBOLS];
    logic [hclb_pkg::LEN_BITS-1:0]   m_len [hclb_pkg::SYMBOLS];
    logic [hclb_pkg::SYM_BITS-1:0]   m_sg  [hclb_pkg::SYMBOLS];
    hclb_pkg::t_heap                 m_heap [hclb_pkg::SYMBOLS+1];

    logic                            cnt_we;
    logic [hclb_pkg::SYM_BITS-1:0]   cnt_wa, cnt_ra;
    logic [hclb_pkg::COUNT_BITS-1:0] cnt_wd, cnt_rd;
    logic                            len_we;
    logic [hclb_pkg::SYM_BITS-1:0]   len_ra;
    logic [hclb_pkg::LEN_BITS-1:0]   len_wd, len_rd;
    logic                            sg_we;
    logic [hclb_pkg::SYM_BITS-1:0]   sg_wd, sg_rd;
    logic                            heap_we;
    logic [hclb_pkg::HIDX_BITS-1:0]  heap_wa, heap_ra;
    hclb_pkg::t_heap                 heap_wd, heap_rd;

    // Control and working registers
    logic [4:0]                      r_state, n_state;
    logic [7:0]                      r_s, n_s;        // symbol scan index, 0..128
    logic [7:0]                      r_top, n_top;    // next free heap slot
    logic [7:0]                      r_p, n_p;        // hole position
    hclb_pkg::t_heap                 r_item, n_item;  // entry being sifted
    hclb_pkg::t_heap                 r_left, n_left;
    hclb_pkg::t_heap                 r_m1, n_m1, r_m2, n_m2;
    logic                            r_pop_n, n_pop_n;
    logic                            r_ret, n_ret;    // 0: insert scan, 1: merge
    logic [7:0]                      r_dist, n_dist;
    logic [hclb_pkg::SYMBOLS-1:0]    r_cv, n_cv;      // count entry valid
    logic [hclb_pkg::SYMBOLS-1:0]    r_lv, n_lv;      // length entry valid
    logic                            r_strobe, n_strobe;
    hclb_pkg::t_rsp                  r_rsp, n_rsp;

    logic                            accept;
    logic [hclb_pkg::SYM_BITS-1:0]   s7;
    logic [8:0]                      lft, rgt;
    logic [hclb_pkg::COUNT_BITS-1:0] cnt_cur;
    logic [hclb_pkg::LEN_BITS-1:0]   len_cur;
    logic [hclb_pkg::WEIGHT_BITS:0]  wsum;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;
    assign s7       = r_s[hclb_pkg::SYM_BITS-1:0];
    assign lft      = {r_p, 1'b0};
    assign rgt      = {r_p, 1'b1};
    assign wsum     = {1'b0, r_m1.weight} + {1'b0, r_m2.weight};

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_cnt[cnt_wa] <= cnt_wd;
        end
        cnt_rd <= m_cnt[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            m_len[s7] <= len_wd;
        end
        len_rd <= m_len[len_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sg_we) begin
            m_sg[s7] <= sg_wd;
        end
        sg_rd <= m_sg[s7];
    end

    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            m_heap[heap_wa] <= heap_wd;
        end
        heap_rd <= m_heap[heap_ra];
    end

    always_comb begin
        n_state  = r_state;
        n_s      = r_s;
        n_top    = r_top;
        n_p      = r_p;
        n_item   = r_item;
        n_left   = r_left;
        n_m1     = r_m1;
        n_m2     = r_m2;
        n_pop_n  = r_pop_n;
        n_ret    = r_ret;
        n_dist   = r_dist;
        n_cv     = r_cv;
        n_lv     = r_lv;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;

        cnt_we  = 1'b0;
        cnt_wa  = i_req.symbol;
        cnt_wd  = '0;
        cnt_ra  = (r_state == S_IDLE) ? i_req.symbol : s7;
        len_we  = 1'b0;
        len_wd  = '0;
        len_ra  = (r_state == S_IDLE) ? i_req.symbol : s7;
        sg_we   = 1'b0;
        sg_wd   = s7;
        heap_we = 1'b0;
        heap_wa = r_p;
        heap_wd = r_item;
        heap_ra = r_p;

        cnt_cur = r_cv[cnt_wa] ? cnt_rd : '0;
        len_cur = r_lv[s7] ? len_rd : '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_s = {1'b0, i_req.symbol};
                    case (i_req.action)
                        hclb_pkg::ACT_COUNT: begin
                            if (i_req.symbol != hclb_pkg::NEWLINE) begin
                                n_state = S_CNT;
                            end
                        end
                        hclb_pkg::ACT_BUILD: begin
                            n_lv    = '0;
                            n_s     = '0;
                            n_top   = 8'd1;
                            n_dist  = '0;
                            n_ret   = 1'b0;
                            n_state = S_INS;
                        end
                        hclb_pkg::ACT_READ: begin
                            n_state = S_RDL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CNT: begin
                cnt_wa  = s7;
                cnt_cur = r_cv[s7] ? cnt_rd : '0;
                cnt_we  = 1'b1;
                cnt_wd  = (cnt_cur == hclb_pkg::COUNT_MAX) ? cnt_cur
                                                           : cnt_cur + 1'b1;
                n_cv[s7] = 1'b1;
                n_state  = S_IDLE;
            end
            S_RDL: begin
                n_strobe = 1'b1;
                n_rsp    = '{reply_kind: hclb_pkg::KIND_READ,
                             distinct_symbols: 8'd0, code_length: len_cur};
                n_state  = S_IDLE;
            end
            // histogram scan: push every present symbol
            S_INS: begin
                if (r_s[7]) begin
                    n_state = S_CHK;
                end else if (r_cv[s7]) begin
                    n_state = S_INSG;
                end else begin
                    n_s = r_s + 8'd1;
                end
            end
            S_INSG: begin
                n_item  = '{weight: hclb_pkg::WEIGHT_BITS'(cnt_rd), group: s7};
                n_p     = r_top;
                n_top   = r_top + 8'd1;
                n_dist  = r_dist + 8'd1;
                sg_we   = 1'b1;
                n_state = S_SUR;
            end
            // sift up with a hole: parent moves down until item fits
            S_SUR: begin
                heap_ra = {1'b0, r_p[7:1]};
                if (r_p == 8'd1) begin
                    heap_we = 1'b1;
                    if (r_ret) begin
                        n_state = S_CHK;
                    end else begin
                        n_s     = r_s + 8'd1;
                        n_state = S_INS;
                    end
                end else begin
                    n_state = S_SUC;
                end
            end
            S_SUC: begin
                heap_we = 1'b1;
                if (r_item.weight < heap_rd.weight) begin
                    heap_wd = heap_rd;
                    n_p     = {1'b0, r_p[7:1]};
                    n_state = S_SUR;
                end else if (r_ret) begin
                    n_state = S_CHK;
                end else begin
                    n_s     = r_s + 8'd1;
                    n_state = S_INS;
                end
            end
            S_CHK: begin
                n_pop_n = 1'b0;
                n_state = (r_top > 8'd2) ? S_POP0 : S_DONE;
            end
            S_POP0: begin
                heap_ra = 8'd1;
                n_state = S_POP1;
            end
            S_POP1: begin
                if (r_pop_n) begin
                    n_m2 = heap_rd;
                end else begin
                    n_m1 = heap_rd;
                end
                n_top   = r_top - 8'd1;
                heap_ra = r_top - 8'd1;
                n_state = S_POP2;
            end
            S_POP2: begin
                n_item  = heap_rd;
                n_p     = 8'd1;
                n_state = S_SD;
            end
            // sift down; ties between children take the right one
            S_SD: begin
                heap_ra = lft[hclb_pkg::HIDX_BITS-1:0];
                if (rgt < {1'b0, r_top}) begin
                    n_state = S_SDL;
                end else if (lft < {1'b0, r_top}) begin
                    n_state = S_SDL1;
                end else begin
                    heap_we = 1'b1;
                    if (r_pop_n) begin
                        n_s     = '0;
                        n_state = S_MRG;
                    end else begin
                        n_pop_n = 1'b1;
                        n_state = S_POP0;
                    end
                end
            end
            S_SDL: begin
                n_left  = heap_rd;
                heap_ra = rgt[hclb_pkg::HIDX_BITS-1:0];
                n_state = S_SDR;
            end
            S_SDR: begin
                heap_we = 1'b1;
                if (r_item.weight > r_left.weight || r_item.weight > heap_rd.weight) begin
                    if (r_left.weight < heap_rd.weight) begin
                        heap_wd = r_left;
                        n_p     = lft[hclb_pkg::HIDX_BITS-1:0];
                    end else begin
                        heap_wd = heap_rd;
                        n_p     = rgt[hclb_pkg::HIDX_BITS-1:0];
                    end
                    n_state = S_SD;
                end else if (r_pop_n) begin
                    n_s     = '0;
                    n_state = S_MRG;
                end else begin
                    n_pop_n = 1'b1;
                    n_state = S_POP0;
                end
            end
            S_SDL1: begin
                heap_we = 1'b1;
                if (r_item.weight > heap_rd.weight) begin
                    heap_wd = heap_rd;
                    n_p     = lft[hclb_pkg::HIDX_BITS-1:0];
                    n_state = S_SD;
                end else if (r_pop_n) begin
                    n_s     = '0;
                    n_state = S_MRG;
                end else begin
                    n_pop_n = 1'b1;
                    n_state = S_POP0;
                end
            end
            // group scan: members of both popped groups gain one bit
            S_MRG: begin
                if (r_s[7]) begin
                    n_item  = '{weight: wsum[hclb_pkg::WEIGHT_BITS-1:0],
                                group: r_m1.group};
                    n_p     = r_top;
                    n_top   = r_top + 8'd1;
                    n_ret   = 1'b1;
                    n_state = S_SUR;
                end else if (r_cv[s7]) begin
                    n_state = S_MRG2;
                end else begin
                    n_s = r_s + 8'd1;
                end
            end
            S_MRG2: begin
                if (sg_rd == r_m1.group || sg_rd == r_m2.group) begin
                    len_we   = 1'b1;
                    len_wd   = (len_cur == hclb_pkg::LEN_MAX) ? len_cur
                                                              : len_cur + 1'b1;
                    n_lv[s7] = 1'b1;
                    sg_we    = 1'b1;
                    sg_wd    = r_m1.group;
                end
                n_s     = r_s + 8'd1;
                n_state = S_MRG;
            end
            S_DONE: begin
                n_cv     = '0;
                n_strobe = 1'b1;
                n_rsp    = '{reply_kind: hclb_pkg::KIND_BUILD,
                             distinct_symbols: r_dist, code_length: '0};
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_top    <= 8'd1;
            r_pop_n  <= 1'b0;
            r_ret    <= 1'b0;
            r_cv     <= '0;
            r_lv     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_top    <= n_top;
            r_pop_n  <= n_pop_n;
            r_ret    <= n_ret;
            r_cv     <= n_cv;
            r_lv     <= n_lv;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s    <= n_s;
        r_p    <= n_p;
        r_item <= n_item;
        r_left <= n_left;
        r_m1   <= n_m1;
        r_m2   <= n_m2;
        r_dist <= n_dist;
        r_rsp  <= n_rsp;
    end

endmodule

### design/hclb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hclb_checker
// Port-level checks of the Huffman code length builder.
// ----------------------------------------------------------------------------
module hclb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input hclb_pkg::t_req i_req,
    input logic           busy,
    input logic           o_strobe,
    input hclb_pkg::t_rsp o_rsp
);

    // replies never come in back-to-back cycles
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back reply strobes");

    // a read request is answered by a read reply strobe
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.action == hclb_pkg::ACT_READ)
        |-> ##2 (o_strobe && o_rsp.reply_kind == hclb_pkg::KIND_READ))
        else $error("read reply missing");

    // a build keeps the block busy
    a_build_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.action == hclb_pkg::ACT_BUILD) |=> busy)
        else $error("build did not raise busy");

    // unused reply field is zero
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_rsp.reply_kind ? (o_rsp.distinct_symbols == 8'd0)
                                       : (o_rsp.code_length == '0)))
        else $error("unused reply field not zero");

endmodule

bind huffman_code_length_builder hclb_checker u_hclb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_req    (i_req),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);

### sim/tb_huffman_code_length_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_code_length_builder
// Drives count, build and read requests into the code length builder and
// checks every reply against a built-in heap-based length predictor.
// ----------------------------------------------------------------------------
module tb_huffman_code_length_builder;

    // Expected replies plus the predicted histogram and length table.
    class reply_scoreboard;
        hclb_pkg::t_rsp                          pending[$];
        logic [hclb_pkg::COUNT_BITS-1:0]         hist[hclb_pkg::SYMBOLS];
        logic [hclb_pkg::LEN_BITS-1:0]           lens[hclb_pkg::SYMBOLS];
        logic [hclb_pkg::WEIGHT_BITS-1:0]        hw[hclb_pkg::SYMBOLS+1];
        logic [hclb_pkg::SYM_BITS-1:0]           hg[hclb_pkg::SYMBOLS+1];
        logic [hclb_pkg::SYM_BITS-1:0]           grp[hclb_pkg::SYMBOLS];
        int                                      top;
        int                                      errors;

        function new();
            foreach (hist[s]) begin
                hist[s] = '0;
                lens[s] = '0;
                grp[s]  = '0;
            end
            errors = 0;
        endfunction

        function void hswap(int a, int b);
            logic [hclb_pkg::WEIGHT_BITS-1:0] w;
            logic [hclb_pkg::SYM_BITS-1:0]    g;
            w = hw[a]; g = hg[a];
            hw[a] = hw[b]; hg[a] = hg[b];
            hw[b] = w; hg[b] = g;
        endfunction

        function void sift_up(int p);
            while (p > 1 && hw[p] < hw[p/2]) begin
                hswap(p, p/2);
                p = p / 2;
            end
        endfunction

        function void pop_min(output logic [hclb_pkg::WEIGHT_BITS-1:0] w,
                              output logic [hclb_pkg::SYM_BITS-1:0] g);
            int p, l, r, c;
            p = 1;
            w = hw[1]; g = hg[1];
            top--;
            hw[1] = hw[top]; hg[1] = hg[top];
            forever begin
                l = 2*p; r = 2*p + 1;
                if (r < top) begin
                    if (hw[p] > hw[l] || hw[p] > hw[r]) begin
                        c = (hw[l] < hw[r]) ? l : r;   // tie goes right
                        hswap(p, c);
                        p = c;
                    end else break;
                end else if (l < top) begin
                    if (hw[p] > hw[l]) begin
                        hswap(p, l);
                        p = l;
                    end else break;
                end else break;
            end
        endfunction

        function int build_lengths();
            int distinct;
            logic [hclb_pkg::WEIGHT_BITS-1:0] w1, w2;
            logic [hclb_pkg::SYM_BITS-1:0] g1, g2;
            distinct = 0;
            foreach (lens[s]) lens[s] = '0;
            top = 1;
            for (int s = 0; s < hclb_pkg::SYMBOLS; s++) begin
                if (hist[s] != 0) begin
                    hw[top] = hclb_pkg::WEIGHT_BITS'(hist[s]);
                    hg[top] = hclb_pkg::SYM_BITS'(s);
                    grp[s]  = hclb_pkg::SYM_BITS'(s);
                    top++;
                    sift_up(top - 1);
                    distinct++;
                end
            end
            while (top > 2) begin
                pop_min(w1, g1);
                pop_min(w2, g2);
                for (int s = 0; s < hclb_pkg::SYMBOLS; s++) begin
                    if (hist[s] != 0 && (grp[s] == g1 || grp[s] == g2)) begin
                        if (lens[s] < hclb_pkg::LEN_MAX) lens[s]++;
                        grp[s] = g1;
                    end
                end
                hw[top] = w1 + w2;
                hg[top] = g1;
                top++;
                sift_up(top - 1);
            end
            foreach (hist[s]) hist[s] = '0;
            return distinct;
        endfunction

        function void note_request(hclb_pkg::t_req rq);
            hclb_pkg::t_rsp rs;
            rs = '0;
            case (rq.action)
                hclb_pkg::ACT_COUNT: begin
                    if (rq.symbol != hclb_pkg::NEWLINE &&
                        hist[rq.symbol] != hclb_pkg::COUNT_MAX)
                        hist[rq.symbol]++;
                end
                hclb_pkg::ACT_BUILD: begin
                    rs.reply_kind       = hclb_pkg::KIND_BUILD;
                    rs.distinct_symbols = 8'(build_lengths());
                    pending.push_back(rs);
                end
                hclb_pkg::ACT_READ: begin
                    rs.reply_kind  = hclb_pkg::KIND_READ;
                    rs.code_length = lens[rq.symbol];
                    pending.push_back(rs);
                end
                default: ;
            endcase
        endfunction

        function void check_reply(hclb_pkg::t_rsp got);
            hclb_pkg::t_rsp exp_rsp;
            if (pending.size() == 0) begin
                $error("unexpected reply %h", got);
                errors++;
                return;
            end
            exp_rsp = pending.pop_front();
            if (got.reply_kind !== exp_rsp.reply_kind) begin
                $error("reply_kind exp %0d got %0d", exp_rsp.reply_kind, got.reply_kind);
                errors++;
            end
            if (got.distinct_symbols !== exp_rsp.distinct_symbols) begin
                $error("distinct_symbols exp %0d got %0d",
                       exp_rsp.distinct_symbols, got.distinct_symbols);
                errors++;
            end
            if (got.code_length !== exp_rsp.code_length) begin
                $error("code_length exp %0d got %0d", exp_rsp.code_length, got.code_length);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 4_000_000;

    logic           clk;
    logic           rst_n;
    logic           start;
    hclb_pkg::t_req req;
    logic           busy;
    logic           strobe;
    hclb_pkg::t_rsp rsp;
    longint         cycles = 0;
    int             sent;

    reply_scoreboard sb;

    huffman_code_length_builder i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .i_req   (req),
        .busy    (busy),
        .o_strobe(strobe),
        .o_rsp   (rsp)
    );

    always begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // Replies cannot be held off, so every strobe is checked on the edge.
    always @(posedge clk) begin
        if (rst_n && strobe) sb.check_reply(rsp);
    end

    // Watchdog: the cycle limit is ample for the builds in this run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** huffman_code_length_builder: FAILED **");
            $finish;
        end
    end

    // Hold start for one accepted request; the scoreboard records it at the
    // accepting edge. Without keep, start drops for one idle cycle.
    task automatic send_request(logic [1:0] act, logic [hclb_pkg::SYM_BITS-1:0] sym,
                                bit keep);
        start <= 1'b1;
        req   <= '{action: act, symbol: sym};
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request('{action: act, symbol: sym});
        sent++;
        if (!keep) begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Random idle gap between requests, with plenty of back-to-back stretches.
    task automatic maybe_gap();
        int n;
        if ($urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            n = $urandom_range(1, 6);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic count_burst(int n, int span);
        for (int i = 0; i < n; i++) begin
            send_request(hclb_pkg::ACT_COUNT,
                         hclb_pkg::SYM_BITS'($urandom_range(0, span)), 1'b1);
            maybe_gap();
        end
    endtask

    task automatic read_all_used(int n);
        for (int i = 0; i < n; i++) begin
            send_request(hclb_pkg::ACT_READ,
                         hclb_pkg::SYM_BITS'($urandom_range(0, 127)), 1'b1);
            maybe_gap();
        end
    endtask

    initial begin
        sb    = new();
        sent  = 0;
        start = 1'b0;
        req   = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reads after reset, empty build, single symbol, newline,
        // unused action, extremes of the symbol field, tie-heavy weights.
        send_request(hclb_pkg::ACT_READ, 7'd0, 1'b0);
        send_request(hclb_pkg::ACT_READ, 7'd127, 1'b0);
        send_request(hclb_pkg::ACT_BUILD, 7'd0, 1'b0);
        send_request(hclb_pkg::ACT_COUNT, 7'd127, 1'b1);
        send_request(hclb_pkg::ACT_COUNT, hclb_pkg::NEWLINE, 1'b1);
        send_request(hclb_pkg::ACT_UNUSED, 7'd5, 1'b1);
        send_request(hclb_pkg::ACT_BUILD, 7'h7f, 1'b1);
        send_request(hclb_pkg::ACT_READ, 7'd127, 1'b1);
        send_request(hclb_pkg::ACT_READ, hclb_pkg::NEWLINE, 1'b0);
        send_request(hclb_pkg::ACT_COUNT, 7'd0, 1'b1);
        send_request(hclb_pkg::ACT_COUNT, 7'd1, 1'b1);
        send_request(hclb_pkg::ACT_COUNT, 7'd2, 1'b1);
        send_request(hclb_pkg::ACT_COUNT, 7'd3, 1'b1);
        send_request(hclb_pkg::ACT_COUNT, 7'd3, 1'b1);
        send_request(hclb_pkg::ACT_COUNT, 7'h55, 1'b1);
        send_request(hclb_pkg::ACT_COUNT, 7'h2a, 1'b1);
        send_request(hclb_pkg::ACT_BUILD, 7'd0, 1'b1);
        send_request(hclb_pkg::ACT_READ, 7'd0, 1'b1);
        send_request(hclb_pkg::ACT_READ, 7'd3, 1'b1);
        send_request(hclb_pkg::ACT_READ, 7'h55, 1'b1);
        send_request(hclb_pkg::ACT_READ, 7'h2a, 1'b0);

        // Random rounds: histogram, build, then reads of random symbols.
        // Small alphabets give deep trees and many ties.
        while (sent < 435) begin
            case ($urandom_range(0, 3))
                0: count_burst($urandom_range(0, 3), 127);
                1: count_burst($urandom_range(5, 40), $urandom_range(1, 15));
                2: count_burst($urandom_range(20, 60), 127);
                default: count_burst($urandom_range(2, 20), $urandom_range(1, 127));
            endcase
            if ($urandom_range(0, 9) == 0)
                send_request(hclb_pkg::ACT_UNUSED, hclb_pkg::SYM_BITS'($urandom), 1'b1);
            send_request(hclb_pkg::ACT_BUILD, hclb_pkg::SYM_BITS'($urandom), 1'b1);
            read_all_used($urandom_range(3, 12));
            start <= 1'b0;
            @(posedge clk);
        end

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0) begin
            $display("** huffman_code_length_builder: PASSED **");
        end else begin
            $display("** huffman_code_length_builder: FAILED **");
        end
        $finish;
    end
endmodule
